FILE: design/tabx_pkg.sv
// Shared types and constants for the tab expander.
// No dependencies; imported by every module of the block.
package tabx_pkg;

    localparam int COL_W = 16;
    localparam int IDX_W = 3;

    typedef logic [COL_W-1:0] t_col;
    typedef logic [COL_W:0]   t_ext;
    typedef logic [7:0]       t_byte;
    typedef logic [IDX_W-1:0] t_idx;

    localparam t_byte CH_TAB      = 8'd9;
    localparam t_byte CH_NL       = 8'd10;
    localparam t_byte CH_SPACE    = 8'd32;
    localparam t_byte DEFAULT_INC = 8'd8;
    localparam t_col  COL_MAX     = 16'hFFFF;

    // Configuration register indexes
    localparam t_idx REG_TAB_INC = 3'd0;
    localparam t_idx REG_STOP_0  = 3'd1;

    // Result of scanning the listed stops
    typedef struct packed {
        logic hit;       // a listed stop lies beyond the column
        t_idx hit_idx;
        t_col hit_stop;
        t_idx end_idx;   // first position past the usable list
        t_ext max_stop;  // largest of the pending candidate and usable stops
    } t_stop_sel;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

FILE: design/tab_expander.sv
// Tab expander top level: registers, byte path, result register, assertions.
// Depends on tabx_pkg, tabx_stop_sel, tabx_phase_div.
//
// One result beat per input beat: a tab becomes a space with a repeat count
// up to the next tab stop, a newline passes and resets the column, any other
// byte passes once and advances the column. Each byte goes through an input
// register, then a result register, at one byte per clock unless a config
// recompute or result back-pressure stalls it; all stop selection and column
// arithmetic for a byte is combinational between those registers. The
// distance to the next repeating stop is tracked per byte, so every
// config write starts a recompute (a setup flag, then a 16-step bit-serial
// remainder) with o_in_ready low. The config port is always ready.
module tab_expander #(
    parameter int NUM_STOPS = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  tabx_pkg::t_byte       i_char_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output tabx_pkg::t_byte       o_out_char,
    output tabx_pkg::t_col        o_repeat_count,
    output logic                  o_column_overflow,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  tabx_pkg::t_idx        i_cfg_index,
    input  tabx_pkg::t_col        i_cfg_data
);
    import tabx_pkg::*;

    // configuration
    t_byte r_inc;
    t_col  r_stop [NUM_STOPS];

    // line state
    t_col  r_column;
    t_ext  r_nsc;
    t_idx  r_idx;
    t_ext  r_base;   // column from which the repeating stops apply
    t_byte r_dist;   // distance to the next repeating stop once past r_base
    logic  r_cfg_pend;

    // pipeline
    logic  r_in_valid;
    t_byte r_in_char;
    logic  r_out_valid;
    t_byte r_out_char;
    t_col  r_out_count;
    logic  r_out_ovf;

    t_col  n_column;
    t_ext  n_nsc;
    t_idx  n_idx;
    t_ext  n_base;
    t_byte n_dist;
    t_byte res_char;
    t_col  res_count;
    logic  res_ovf;

    t_byte     inc_eff;
    t_stop_sel sel;
    t_stop_sel sel_nl;
    t_ext      nl_nsc;
    t_ext      nl_base;
    t_ext      col_ext;
    t_ext      col_inc;
    t_ext      target;
    t_ext      gap;
    t_col      div_numer;
    t_div_stat div_stat;
    t_byte     div_dist;
    logic      in_acc;
    logic      cfg_acc;
    logic      adv;

    assign inc_eff = (r_inc == '0) ? 8'd1 : r_inc;
    assign col_ext = {1'b0, r_column};
    assign col_inc = col_ext + 1'b1;

    tabx_stop_sel #(.NUM_STOPS(NUM_STOPS)) u_sel (
        .i_stops  (r_stop),
        .i_idx    (r_idx),
        .i_column (r_column),
        .i_nsc    (r_nsc),
        .o_sel    (sel)
    );

    // start-of-line view of the list
    tabx_stop_sel #(.NUM_STOPS(NUM_STOPS)) u_sel_nl (
        .i_stops  (r_stop),
        .i_idx    ('0),
        .i_column ('0),
        .i_nsc    ('0),
        .o_sel    (sel_nl)
    );

    assign nl_nsc  = sel_nl.hit ? {1'b0, sel_nl.hit_stop} : {9'd0, inc_eff};
    assign nl_base = sel_nl.hit ? sel_nl.max_stop : {9'd0, inc_eff};

    assign div_numer = (col_ext >= sel.max_stop) ? COL_W'(col_ext - sel.max_stop) : '0;

    tabx_phase_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cfg_pend),
        .i_numer (div_numer),
        .i_inc   (inc_eff),
        .o_stat  (div_stat),
        .o_dist  (div_dist)
    );

    assign adv         = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = (!r_in_valid || adv) && !r_cfg_pend && !div_stat.busy;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    always_comb begin
        n_column  = r_column;
        n_nsc     = r_nsc;
        n_idx     = r_idx;
        n_base    = r_base;
        n_dist    = r_dist;
        res_char  = r_in_char;
        res_count = 16'd1;
        res_ovf   = 1'b0;
        target    = '0;
        gap       = '0;
        case (r_in_char)
            CH_NL: begin
                n_column = '0;
                n_nsc    = nl_nsc;
                n_idx    = '0;
                n_base   = nl_base;
            end
            CH_TAB: begin
                if (r_nsc > col_ext) begin
                    target = r_nsc;
                end else if (sel.hit) begin
                    target = {1'b0, sel.hit_stop};
                    n_nsc  = target;
                    n_idx  = sel.hit_idx;
                end else begin
                    // past every listed stop: repeating stops
                    target = col_ext + {9'd0, r_dist};
                    n_nsc  = target;
                    n_idx  = sel.end_idx;
                    n_base = target;
                end
                gap       = target - col_ext;
                res_count = gap[COL_W] ? COL_MAX : gap[COL_W-1:0];
                if (target[COL_W]) begin
                    n_column = COL_MAX;
                    res_ovf  = 1'b1;
                end else begin
                    n_column = target[COL_W-1:0];
                end
                n_dist   = inc_eff;
                res_char = CH_SPACE;
            end
            default: begin
                if (r_column == COL_MAX) begin
                    res_ovf = 1'b1;
                end else begin
                    n_column = col_inc[COL_W-1:0];
                    if (col_inc == r_base) begin
                        n_dist = inc_eff;
                    end else if (col_ext >= r_base) begin
                        n_dist = (r_dist == 8'd1) ? inc_eff : r_dist - 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc       <= DEFAULT_INC;
            for (int j = 0; j < NUM_STOPS; j++) begin
                r_stop[j] <= '0;
            end
            r_column    <= '0;
            r_nsc       <= {9'd0, DEFAULT_INC};
            r_idx       <= '0;
            r_base      <= {9'd0, DEFAULT_INC};
            r_dist      <= DEFAULT_INC;
            r_cfg_pend  <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cfg_pend <= cfg_acc;
            if (cfg_acc) begin
                if (i_cfg_index == REG_TAB_INC) begin
                    r_inc <= i_cfg_data[7:0];
                end
                for (int j = 0; j < NUM_STOPS; j++) begin
                    if (i_cfg_index == REG_STOP_0 + IDX_W'(j)) begin
                        r_stop[j] <= i_cfg_data;
                    end
                end
            end

            if (adv) begin
                r_column <= n_column;
                r_nsc    <= n_nsc;
                r_idx    <= n_idx;
                r_base   <= n_base;
                r_dist   <= n_dist;
            end else begin
                if (r_cfg_pend) begin
                    r_base <= sel.max_stop;
                end
                if (div_stat.done) begin
                    r_dist <= div_dist;
                end
            end

            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end

            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_char <= i_char_in;
        end
        if (adv) begin
            r_out_char  <= res_char;
            r_out_count <= res_count;
            r_out_ovf   <= res_ovf;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_char        = r_out_char;
    assign o_repeat_count    = r_out_count;
    assign o_column_overflow = r_out_ovf;

    // tracked distance stays within one increment once past the base column
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_cfg_pend && !div_stat.busy && !div_stat.done && (col_ext >= r_base))
        |-> (r_dist != 8'd0 && r_dist <= inc_eff))
        else $error("repeat distance out of range");

    a_base_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_cfg_pend && !div_stat.busy) |-> (r_base >= r_nsc))
        else $error("base column below pending stop");

    a_single_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_char != CH_SPACE) |-> (o_repeat_count == 16'd1))
        else $error("non-space beat with repeat count other than one");

endmodule

FILE: design/tabx_stop_sel.sv
// Listed tab stop scan: next stop beyond the column, end of list, largest stop.
// Depends on tabx_pkg.
module tabx_stop_sel #(
    parameter int NUM_STOPS = 6
) (
    input  tabx_pkg::t_col      i_stops [NUM_STOPS],
    input  tabx_pkg::t_idx      i_idx,
    input  tabx_pkg::t_col      i_column,
    input  tabx_pkg::t_ext      i_nsc,
    output tabx_pkg::t_stop_sel o_sel
);
    import tabx_pkg::*;

    localparam t_idx NUM_IDX = IDX_W'(NUM_STOPS);

    always_comb begin
        logic ok;
        t_stop_sel s;
        ok         = 1'b1;
        s.hit      = 1'b0;
        s.hit_idx  = i_idx;
        s.hit_stop = '0;
        s.end_idx  = NUM_IDX;
        s.max_stop = i_nsc;
        for (int j = 0; j < NUM_STOPS; j++) begin
            if (IDX_W'(j) >= i_idx) begin
                if (ok && i_stops[j] == '0) begin
                    ok        = 1'b0;
                    s.end_idx = IDX_W'(j);
                end
                if (ok) begin
                    if ({1'b0, i_stops[j]} > s.max_stop) begin
                        s.max_stop = {1'b0, i_stops[j]};
                    end
                    if (!s.hit && i_stops[j] > i_column) begin
                        s.hit      = 1'b1;
                        s.hit_idx  = IDX_W'(j);
                        s.hit_stop = i_stops[j];
                    end
                end
            end
        end
        o_sel = s;
    end

endmodule

FILE: design/tabx_phase_div.sv
// Bit-serial remainder unit: distance to the next repeating stop after a
// configuration change. Depends on tabx_pkg.
module tabx_phase_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  tabx_pkg::t_col      i_numer,
    input  tabx_pkg::t_byte     i_inc,
    output tabx_pkg::t_div_stat o_stat,
    output tabx_pkg::t_byte     o_dist
);
    import tabx_pkg::*;

    localparam int STEPS = COL_W;
    localparam int CNT_W = $clog2(STEPS);

    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    t_col             r_num;
    t_byte            r_rem;
    t_byte            r_inc;
    logic [8:0]       rem_sh;
    t_byte            n_rem;

    always_comb begin
        rem_sh = {r_rem, r_num[COL_W-1]};
        if (rem_sh >= {1'b0, r_inc}) begin
            n_rem = 8'(rem_sh - {1'b0, r_inc});
        end else begin
            n_rem = rem_sh[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_numer;
            r_rem <= '0;
            r_inc <= i_inc;
        end else if (r_busy) begin
            r_num <= {r_num[COL_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    // remainder < inc, so the distance is 1..inc
    assign o_dist      = r_inc - r_rem;

endmodule

FILE: tb/tab_expander_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for tab_expander: directed rows, then random text phases.
// Depends on tabx_pkg and the tab_expander RTL; expected beats come from typed rows or a local predictor.
module tab_expander_tb;
    import tabx_pkg::*;

    localparam int N_STOPS   = 6;
    localparam int N_RANDOM  = 1550;

    typedef struct packed {
        t_byte ch;
        t_col  cnt;
        logic  ovf;
    } t_beat;

    typedef enum logic {ROW_BYTE, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind kind;
        t_idx      idx;
        t_col      val;
        bit        known;
        t_beat     want;
    } t_row;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_in_valid;
    logic  o_in_ready;
    t_byte i_char_in;
    logic  o_out_valid;
    logic  i_out_ready;
    t_byte o_out_char;
    t_col  o_repeat_count;
    logic  o_column_overflow;
    logic  i_cfg_valid;
    logic  o_cfg_ready;
    t_idx  i_cfg_index;
    t_col  i_cfg_data;

    tab_expander #(.NUM_STOPS(N_STOPS)) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_char_in         (i_char_in),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_out_char        (o_out_char),
        .o_repeat_count    (o_repeat_count),
        .o_column_overflow (o_column_overflow),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("tab_expander_tb NOT OK");
        $finish;
    end

    // Predictor state: register copies plus line position
    logic [7:0]  inc_reg;
    t_col        stop_reg [N_STOPS];
    t_col        col_now;
    int unsigned stop_cand;
    int          stop_pos;

    t_beat due_beats [$];
    int    mismatches = 0;

    function automatic int unsigned inc_step();
        return (inc_reg == 0) ? 1 : inc_reg;
    endfunction

    function automatic bit stop_live();
        return stop_pos < N_STOPS && stop_reg[stop_pos] != 0;
    endfunction

    // Advance to the first listed stop past the candidate; 0 once the list is used up.
    function automatic bit walk_stops();
        while (stop_live() && stop_reg[stop_pos] <= stop_cand)
            stop_pos++;
        if (stop_live()) begin
            stop_cand = stop_reg[stop_pos];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void line_start();
        stop_pos  = 0;
        stop_cand = 0;
        if (!walk_stops())
            stop_cand = inc_step();
    endfunction

    function automatic t_beat expand_byte(t_byte c);
        t_beat       r;
        int unsigned gap;
        int unsigned k;
        r.ch  = c;
        r.cnt = 1;
        r.ovf = 1'b0;
        if (c == CH_NL) begin
            col_now = '0;
            line_start();
        end else if (c == CH_TAB) begin
            for (int i = 0; i < 2 * N_STOPS + 2 && stop_cand <= col_now; i++)
                if (!walk_stops())
                    break;
            if (stop_cand <= col_now) begin
                k = (col_now - stop_cand) / inc_step() + 1;
                stop_cand += k * inc_step();
            end
            gap   = stop_cand - col_now;
            r.cnt = (gap > COL_MAX) ? COL_MAX : t_col'(gap);
            if (stop_cand > COL_MAX) begin
                col_now = COL_MAX;
                r.ovf   = 1'b1;
            end else begin
                col_now = t_col'(stop_cand);
            end
            r.ch = CH_SPACE;
        end else begin
            if (col_now == COL_MAX)
                r.ovf = 1'b1;
            else
                col_now++;
        end
        return r;
    endfunction

    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_byte pick_char(int nl_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 18)
            return CH_TAB;
        if (r < 18 + nl_pct)
            return CH_NL;
        if (r < 24 + nl_pct)
            return t_byte'($urandom_range(0, 255));
        return t_byte'($urandom_range(32, 126));
    endfunction

    function automatic t_row row_byte(t_byte c);
        t_row r;
        r.kind  = ROW_BYTE;
        r.idx   = REG_TAB_INC;
        r.val   = {8'h00, c};
        r.known = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic t_row row_chk(t_byte c, t_byte ch, t_col cnt, logic ovf);
        t_row r;
        r       = row_byte(c);
        r.known = 1'b1;
        r.want  = '{ch, cnt, ovf};
        return r;
    endfunction

    function automatic t_row row_reg(t_idx idx, t_col v);
        t_row r;
        r.kind  = ROW_REG;
        r.idx   = idx;
        r.val   = v;
        r.known = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    task automatic send_byte(t_byte c, int gap, bit known, t_beat typed);
        t_beat guess;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_char_in  <= c;
        do @(posedge i_clk); while (!o_in_ready);
        guess = expand_byte(c);
        due_beats.push_back(known ? typed : guess);
    endtask

    task automatic cfg_write(t_idx idx, t_col v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_TAB_INC)
            inc_reg = v[7:0];
        else
            stop_reg[idx - REG_STOP_0] = v;
    endtask

    // Hold input, let every expected beat drain, then cover the pipeline depth
    task automatic settle();
        i_in_valid <= 1'b0;
        while (due_beats.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Result side: random back-pressure, alternating with stall-free stretches
    int hold_left = 0;
    int calm_cnt  = 0;
    bit out_calm  = 1'b0;

    always @(posedge i_clk) begin
        if (calm_cnt == 0) begin
            calm_cnt <= $urandom_range(100, 400);
            out_calm <= ($urandom_range(0, 3) == 0);
        end else begin
            calm_cnt <= calm_cnt - 1;
        end
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (!out_calm && $urandom_range(0, 99) < 30) begin
            hold_left   <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                      : $urandom_range(0, 2);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_beats.size() == 0) begin
                $error("unexpected result beat: out_char %0d repeat_count %0d",
                       o_out_char, o_repeat_count);
                mismatches++;
            end else begin
                want = due_beats.pop_front();
                if (o_out_char !== want.ch) begin
                    $error("out_char: expected %0d, got %0d", want.ch, o_out_char);
                    mismatches++;
                end
                if (o_repeat_count !== want.cnt) begin
                    $error("repeat_count: expected %0d, got %0d", want.cnt, o_repeat_count);
                    mismatches++;
                end
                if (o_column_overflow !== want.ovf) begin
                    $error("column_overflow: expected %0d, got %0d",
                           want.ovf, o_column_overflow);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        t_row        plan [$];
        t_col        pick [N_STOPS];
        logic [7:0]  inc_pick;
        int unsigned s;
        int          sent;
        int          n;
        int          p;
        int          mode;
        int          nl_pct;
        bit          calm;
        bit          cfg_open;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_char_in   <= '0;
        i_out_ready <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_TAB_INC;
        i_cfg_data  <= '0;

        inc_reg = DEFAULT_INC;
        foreach (stop_reg[k])
            stop_reg[k] = '0;
        col_now = '0;
        line_start();

        // Reset values: increment 8, empty stop list
        plan.push_back(row_chk("A", "A", 16'd1, 1'b0));
        plan.push_back(row_chk(CH_TAB, CH_SPACE, 16'd7, 1'b0));
        plan.push_back(row_chk(CH_TAB, CH_SPACE, 16'd8, 1'b0));
        plan.push_back(row_chk(CH_NL, CH_NL, 16'd1, 1'b0));
        plan.push_back(row_byte(8'h00));
        plan.push_back(row_byte(8'hFF));
        plan.push_back(row_chk(CH_NL, CH_NL, 16'd1, 1'b0));
        // Zero increment; pending stop at 8 holds until the next newline
        plan.push_back(row_reg(REG_TAB_INC, 16'd0));
        plan.push_back(row_chk(CH_TAB, CH_SPACE, 16'd8, 1'b0));
        plan.push_back(row_chk(CH_NL, CH_NL, 16'd1, 1'b0));
        plan.push_back(row_chk(CH_TAB, CH_SPACE, 16'd1, 1'b0));
        plan.push_back(row_chk(CH_TAB, CH_SPACE, 16'd1, 1'b0));
        // Duplicate stop is skipped, then repeating stops every 255
        plan.push_back(row_reg(REG_TAB_INC, 16'd255));
        plan.push_back(row_reg(REG_STOP_0, 16'd3));
        plan.push_back(row_reg(REG_STOP_0 + t_idx'(1), 16'd3));
        plan.push_back(row_reg(REG_STOP_0 + t_idx'(2), 16'd10));
        plan.push_back(row_chk(CH_NL, CH_NL, 16'd1, 1'b0));
        plan.push_back(row_chk(CH_TAB, CH_SPACE, 16'd3, 1'b0));
        plan.push_back(row_chk(CH_TAB, CH_SPACE, 16'd7, 1'b0));
        plan.push_back(row_chk(CH_TAB, CH_SPACE, 16'd255, 1'b0));
        plan.push_back(row_chk(CH_NL, CH_NL, 16'd1, 1'b0));
        // Column already past the first stop
        plan.push_back(row_byte("a"));
        plan.push_back(row_byte(8'h07));
        plan.push_back(row_byte("c"));
        plan.push_back(row_byte("d"));
        plan.push_back(row_byte(CH_TAB));
        // Stop at the top column, then saturation
        plan.push_back(row_reg(REG_STOP_0, 16'hFFFF));
        plan.push_back(row_reg(REG_STOP_0 + t_idx'(1), 16'd0));
        plan.push_back(row_reg(REG_STOP_0 + t_idx'(2), 16'd0));
        plan.push_back(row_chk(CH_NL, CH_NL, 16'd1, 1'b0));
        plan.push_back(row_chk(CH_TAB, CH_SPACE, 16'hFFFF, 1'b0));
        plan.push_back(row_chk("z", "z", 16'd1, 1'b1));
        plan.push_back(row_chk(CH_TAB, CH_SPACE, 16'd255, 1'b1));
        plan.push_back(row_chk(CH_NL, CH_NL, 16'd1, 1'b0));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        cfg_open = 1'b0;
        foreach (plan[r]) begin
            if (plan[r].kind == ROW_REG) begin
                if (!cfg_open)
                    settle();
                cfg_open = 1'b1;
                cfg_write(plan[r].idx, plan[r].val);
            end else begin
                if (cfg_open)
                    i_cfg_valid <= 1'b0;
                cfg_open = 1'b0;
                send_byte(plan[r].val[7:0], pick_gap(1'b0), plan[r].known, plan[r].want);
            end
        end

        sent = 0;
        p    = 0;
        while (sent < N_RANDOM) begin
            mode = p % 6;
            calm = ($urandom_range(0, 3) == 0);
            case (p % 5)
                0:       inc_pick = 8'd255;
                1:       inc_pick = 8'd0;
                2:       inc_pick = 8'd1;
                default: inc_pick = 8'($urandom_range(1, 255));
            endcase
            s = 0;
            case (mode)
                0: begin
                    foreach (pick[k])
                        pick[k] = '0;
                end
                1: begin
                    foreach (pick[k]) begin
                        s += $urandom_range(1, 24);
                        pick[k] = t_col'(s);
                    end
                end
                2: begin
                    // list ends early; entries after the zero are don't-care
                    foreach (pick[k]) begin
                        s += $urandom_range(1, 30);
                        pick[k] = t_col'(s);
                    end
                    pick[$urandom_range(1, N_STOPS - 1)] = '0;
                end
                3: begin
                    foreach (pick[k])
                        pick[k] = t_col'($urandom_range(1, 40));
                end
                4: begin
                    s = $urandom_range(65000, 65400);
                    foreach (pick[k]) begin
                        pick[k] = (s > COL_MAX) ? COL_MAX : t_col'(s);
                        s += $urandom_range(1, 60);
                    end
                end
                default: begin
                    foreach (pick[k])
                        pick[k] = t_col'($urandom_range(0, 65535));
                end
            endcase

            settle();
            cfg_write(REG_TAB_INC, {8'h00, inc_pick});
            for (int k = 0; k < N_STOPS; k++)
                cfg_write(REG_STOP_0 + t_idx'(k), pick[k]);
            i_cfg_valid <= 1'b0;

            // few newlines with high stops so tabs pile up toward saturation
            nl_pct = (mode == 4) ? 1 : 6;
            n = $urandom_range(90, 150);
            for (int i = 0; i < n; i++) begin
                if ((p == 1 && i == n / 2) || $urandom_range(0, 199) == 0)
                    settle();
                send_byte(pick_char(nl_pct), pick_gap(calm), 1'b0, '0);
            end
            sent += n;
            p++;
        end

        i_in_valid <= 1'b0;
        while (due_beats.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("tab_expander_tb OK");
        else
            $display("tab_expander_tb NOT OK");
        $finish;
    end

endmodule
